/* hdl/vsfr_pkg.sv */
// Shared types and constants for the vocoder serial frame receiver.
// Used by the parser, the output buffer and the top level.
`timescale 1ns / 1ps

package vsfr_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_TYPE  = 2'd2;

  localparam logic [7:0] START_BYTE_RST   = 8'd97;
  localparam logic [7:0] CONTROL_TYPE_RST = 8'd0;
  localparam logic [7:0] SPEECH_TYPE_RST  = 8'd2;

  // Protocol constants
  localparam logic [7:0] CHAN_BASE  = 8'h40;
  localparam logic [7:0] CHAN_TOP   = 8'h42;
  localparam logic [7:0] SPEECH_TAG = 8'h00;

  // Result codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] CLASS_OTHER   = 2'd0;
  localparam logic [1:0] CLASS_CONTROL = 2'd1;
  localparam logic [1:0] CLASS_SPEECH  = 2'd2;

  localparam logic [1:0] STATUS_GOOD   = 2'd0;
  localparam logic [1:0] STATUS_PARITY = 2'd1;
  localparam logic [1:0] STATUS_SHORT  = 2'd2;

  localparam int TDATA_W = 72;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_TYPE   = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    FP_TAG   = 4'b0001,
    FP_COUNT = 4'b0010,
    FP_HIGH  = 4'b0100,
    FP_LOW   = 4'b1000
  } field_phase_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] control_type_code;
    logic [7:0] speech_type_code;
  } cfg_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] sample_value;
    logic [7:0]         sample_index;
    logic [7:0]         frame_type;
    logic [1:0]         frame_class;
    logic [7:0]         control_opcode;
    logic [7:0]         channel_number;
    logic [15:0]        payload_length;
    logic [1:0]         frame_status;
    logic               last;
  } result_t;

  // Control wins when both type codes match
  function automatic logic [1:0] class_of(input logic [7:0] tb, input cfg_t cfg);
    logic [1:0] c;
    c = CLASS_OTHER;
    if (tb == cfg.control_type_code) c = CLASS_CONTROL;
    else if (tb == cfg.speech_type_code) c = CLASS_SPEECH;
    return c;
  endfunction

  function automatic logic is_chan(input logic [7:0] b);
    return (b >= CHAN_BASE) && (b <= CHAN_TOP);
  endfunction

endpackage

/* hdl/vsfr_parser.sv */
// Byte-level frame parser: hunt, length, type, body and speech field decode.
// Depends on vsfr_pkg for state encodings, result struct and helpers.
`timescale 1ns / 1ps

module vsfr_parser (
  input  logic             clk,
  input  logic             rst,
  input  vsfr_pkg::cfg_t   cfg,
  input  logic             in_accept,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output vsfr_pkg::result_t res
);

  vsfr_pkg::phase_t       phase, phase_next;
  vsfr_pkg::field_phase_t field_phase, field_phase_next;
  logic [15:0] length_field, length_field_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  parity_acc, parity_acc_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  opcode_byte, opcode_byte_next;
  logic [7:0]  samples_left, samples_left_next;
  logic [7:0]  sample_high, sample_high_next;
  logic [7:0]  sample_pos, sample_pos_next;

  logic [15:0] pos;
  logic [7:0]  samples_dec;
  logic [1:0]  cls;
  logic        have_payload;

  assign pos         = length_field - bytes_left;
  assign samples_dec = samples_left - 8'd1;

  // Next state and result for the byte in this transaction
  always_comb begin
    phase_next        = phase;
    field_phase_next  = field_phase;
    length_field_next = length_field;
    bytes_left_next   = bytes_left;
    parity_acc_next   = parity_acc;
    type_byte_next    = type_byte;
    first_byte_next   = first_byte;
    opcode_byte_next  = opcode_byte;
    samples_left_next = samples_left;
    sample_high_next  = sample_high;
    sample_pos_next   = sample_pos;
    res_valid         = 1'b0;
    res               = '0;
    res.result_kind   = vsfr_pkg::KIND_STATUS;
    res.last          = 1'b1;

    unique case (phase)
      vsfr_pkg::PH_HUNT: begin
        if (in_byte == cfg.start_byte) begin
          parity_acc_next = '0;
          phase_next      = vsfr_pkg::PH_LEN_HI;
        end
      end
      vsfr_pkg::PH_LEN_HI: begin
        parity_acc_next   = parity_acc ^ in_byte;
        length_field_next = {in_byte, 8'h00};
        phase_next        = vsfr_pkg::PH_LEN_LO;
      end
      vsfr_pkg::PH_LEN_LO: begin
        parity_acc_next   = parity_acc ^ in_byte;
        length_field_next = {length_field[15:8], in_byte};
        phase_next        = vsfr_pkg::PH_TYPE;
      end
      vsfr_pkg::PH_TYPE: begin
        parity_acc_next   = parity_acc ^ in_byte;
        type_byte_next    = in_byte;
        first_byte_next   = '0;
        opcode_byte_next  = '0;
        field_phase_next  = vsfr_pkg::FP_TAG;
        samples_left_next = '0;
        sample_high_next  = '0;
        sample_pos_next   = '0;
        bytes_left_next   = length_field;
        if (length_field < 16'd2) begin
          phase_next       = vsfr_pkg::PH_HUNT;
          res_valid        = 1'b1;
          res.frame_status = vsfr_pkg::STATUS_SHORT;
        end else begin
          phase_next = vsfr_pkg::PH_BODY;
        end
      end
      vsfr_pkg::PH_BODY: begin
        if (bytes_left > 16'd2) begin
          parity_acc_next = parity_acc ^ in_byte;
          bytes_left_next = bytes_left - 16'd1;
          if (pos == 16'd0) begin
            first_byte_next  = in_byte;
            opcode_byte_next = vsfr_pkg::is_chan(in_byte) ? 8'h00 : in_byte;
          end else begin
            if (pos == 16'd2 && vsfr_pkg::is_chan(first_byte)) opcode_byte_next = in_byte;
            if (vsfr_pkg::class_of(type_byte, cfg) == vsfr_pkg::CLASS_SPEECH) begin
              unique case (field_phase)
                vsfr_pkg::FP_TAG: begin
                  if (in_byte == vsfr_pkg::SPEECH_TAG) field_phase_next = vsfr_pkg::FP_COUNT;
                end
                vsfr_pkg::FP_COUNT: begin
                  samples_left_next = in_byte;
                  sample_pos_next   = '0;
                  field_phase_next  = (in_byte == 8'd0) ? vsfr_pkg::FP_TAG
                                                        : vsfr_pkg::FP_HIGH;
                end
                vsfr_pkg::FP_HIGH: begin
                  sample_high_next = in_byte;
                  field_phase_next = vsfr_pkg::FP_LOW;
                end
                vsfr_pkg::FP_LOW: begin
                  res_valid         = 1'b1;
                  res.result_kind   = vsfr_pkg::KIND_SAMPLE;
                  res.last          = 1'b0;
                  res.sample_value  = {sample_high, in_byte};
                  res.sample_index  = sample_pos;
                  sample_pos_next   = sample_pos + 8'd1;
                  samples_left_next = samples_dec;
                  field_phase_next  = (samples_dec == 8'd0) ? vsfr_pkg::FP_TAG
                                                            : vsfr_pkg::FP_HIGH;
                end
                default: ;
              endcase
            end
          end
        end else if (bytes_left == 16'd2) begin
          // parity marker byte: folded into the sum, value not checked
          parity_acc_next = parity_acc ^ in_byte;
          bytes_left_next = 16'd1;
        end else begin
          bytes_left_next  = '0;
          phase_next       = vsfr_pkg::PH_HUNT;
          res_valid        = 1'b1;
          res.frame_status = (parity_acc == in_byte) ? vsfr_pkg::STATUS_GOOD
                                                     : vsfr_pkg::STATUS_PARITY;
        end
      end
      default: ;
    endcase

    // Frame-wide fields reflect the state after this byte
    cls                = vsfr_pkg::class_of(type_byte_next, cfg);
    have_payload       = length_field_next > 16'd2;
    res.frame_type     = type_byte_next;
    res.frame_class    = cls;
    res.payload_length = length_field_next;
    res.control_opcode = (cls == vsfr_pkg::CLASS_CONTROL && have_payload)
                         ? opcode_byte_next : 8'h00;
    res.channel_number = have_payload ? (first_byte_next - vsfr_pkg::CHAN_BASE) : 8'h00;
    if (!in_accept) res_valid = 1'b0;
  end

  // Advance the parser on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vsfr_pkg::PH_HUNT;
      field_phase  <= vsfr_pkg::FP_TAG;
      length_field <= '0;
      bytes_left   <= '0;
      parity_acc   <= '0;
      type_byte    <= '0;
      first_byte   <= '0;
      opcode_byte  <= '0;
      samples_left <= '0;
      sample_high  <= '0;
      sample_pos   <= '0;
    end else if (in_accept) begin
      phase        <= phase_next;
      field_phase  <= field_phase_next;
      length_field <= length_field_next;
      bytes_left   <= bytes_left_next;
      parity_acc   <= parity_acc_next;
      type_byte    <= type_byte_next;
      first_byte   <= first_byte_next;
      opcode_byte  <= opcode_byte_next;
      samples_left <= samples_left_next;
      sample_high  <= sample_high_next;
      sample_pos   <= sample_pos_next;
    end
  end

`ifndef SYNTHESIS
  a_status_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> (phase == vsfr_pkg::PH_HUNT))
    else $error("status result not followed by hunt");
  a_body_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == vsfr_pkg::PH_BODY) |-> (bytes_left != 16'd0))
    else $error("body phase with no bytes left");
`endif

endmodule

/* hdl/vsfr_out_buf.sv */
// Two-entry output register with skid slot for result transactions.
// Depends on vsfr_pkg for the result struct.
`timescale 1ns / 1ps

module vsfr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vsfr_pkg::result_t push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vsfr_pkg::result_t out_data
);

  logic              valid0, valid1;
  vsfr_pkg::result_t buf0, buf1;
  logic              pop;

  assign pop       = valid0 && out_ready;
  assign in_ready  = !valid1;
  assign out_valid = valid0;
  assign out_data  = buf0;

  // Refill the head from the skid slot first, else from the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (!valid0 || pop) begin
      if (valid1) begin
        valid0 <= 1'b1;
        valid1 <= 1'b0;
      end else begin
        valid0 <= push;
      end
    end else if (push) begin
      valid1 <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!valid0 || pop) begin
      buf0 <= valid1 ? buf1 : push_data;
    end else if (push) begin
      buf1 <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_head: assert property (@(posedge clk) disable iff (rst)
    valid1 |-> valid0)
    else $error("skid slot full with empty head");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !valid1)
    else $error("push into full buffer");
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (valid0 && !out_ready) |=> (valid0 && $stable(buf0)))
    else $error("stalled head result changed");
`endif

endmodule

/* hdl/vocoder_serial_frame_receiver.sv */
// Top level of the vocoder serial frame receiver: config registers,
// parser and output buffer. Depends on vsfr_pkg, vsfr_parser, vsfr_out_buf.
`timescale 1ns / 1ps

// Usage:
// - s_axis carries one received serial byte per transaction in s_axis_tdata.
// - m_axis carries results: speech samples (tuser 0) and one end-of-frame
//   status per frame (tuser 1, tlast high). Samples stream out before the
//   parity is checked; drop them if the closing status is not good.
// - cfg_we/cfg_index/cfg_data write start_byte (0), control_type_code (1)
//   and speech_type_code (2); other indexes are ignored. Write only when idle.
// - Throughput: one byte per cycle while s_axis_tready is high. The parser
//   state machine updates in the cycle a byte is taken and its result is
//   registered in the head register, or in the skid slot when the head is held.
// - When the consumer stalls, a skid slot holds one more result; once both
//   slots are full s_axis_tready drops until the head result is taken.
// - Reset (rst, synchronous) returns the parser to hunting for the start
//   byte, empties the output buffer and restores the register defaults
//   (start 0x61, control type 0x00, speech type 0x02).
module vocoder_serial_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] sample_value, [23:16] sample_index, [31:24] frame_type,
  // [33:32] frame_class, [41:34] control_opcode, [49:42] channel_number,
  // [65:50] payload_length, [67:66] frame_status, [71:68] zero
  output logic [vsfr_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                           m_axis_tuser,  // [0] result_kind
  output logic                           m_axis_tlast,
  input  logic                           cfg_we,
  input  logic [vsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  vsfr_pkg::cfg_t    cfg;
  vsfr_pkg::result_t res, head;
  logic              res_valid;
  logic              in_accept;
  logic              buf_ready;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte        <= vsfr_pkg::START_BYTE_RST;
      cfg.control_type_code <= vsfr_pkg::CONTROL_TYPE_RST;
      cfg.speech_type_code  <= vsfr_pkg::SPEECH_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsfr_pkg::REG_START_BYTE:   cfg.start_byte        <= cfg_data;
        vsfr_pkg::REG_CONTROL_TYPE: cfg.control_type_code <= cfg_data;
        vsfr_pkg::REG_SPEECH_TYPE:  cfg.speech_type_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = buf_ready;
  assign in_accept     = s_axis_tvalid && buf_ready;

  vsfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_accept (in_accept),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  vsfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (buf_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata = {4'b0000, head.frame_status, head.payload_length,
                         head.channel_number, head.control_opcode, head.frame_class,
                         head.frame_type, head.sample_index, head.sample_value};
  assign m_axis_tuser = head.result_kind;
  assign m_axis_tlast = head.last;

endmodule
